[rtl/nsf_pkg.sv]
`timescale 1ns / 1ps

package nsf_pkg;

    localparam int SENTENCE_BYTES = 128;
    localparam int FILL_W         = $clog2(SENTENCE_BYTES);
    localparam int ADDR_W         = FILL_W + 1;
    localparam int STORE_DEPTH    = 2 * SENTENCE_BYTES;
    localparam int IDX_W          = 7;
    localparam int LEN_W          = 7;
    localparam int CMP_W          = (FILL_W > IDX_W) ? FILL_W : IDX_W;
    localparam int CNT_W          = 32;
    localparam int TMO_W          = 16;

    localparam int S_TDATA_W      = 16;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 80;
    localparam int M_TUSER_W      = 1;

    localparam logic [7:0]       CH_START      = 8'h24;
    localparam logic [7:0]       CH_CR         = 8'h0D;
    localparam logic [7:0]       CH_LF         = 8'h0A;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] length;
        logic [CNT_W-1:0] dropped;
        logic [CNT_W-1:0] age;
        logic             fresh;
        logic             rd_hit;
    } status_t;

endpackage

[rtl/nsf_store.sv]
`timescale 1ns / 1ps

module nsf_store (
    input  logic             aclk,
    input  nsf_pkg::mem_wr_t wr,
    input  nsf_pkg::mem_rd_t rd,
    output logic [7:0]       rd_data
);
    import nsf_pkg::*;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.re) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/nsf_ctrl.sv]
`timescale 1ns / 1ps

module nsf_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [nsf_pkg::TMO_W-1:0] cfg_wdata,
    input  logic                      accept,
    input  nsf_pkg::cmd_t             cmd,
    input  logic [7:0]                rx_byte,
    input  logic [nsf_pkg::IDX_W-1:0] read_index,
    output nsf_pkg::mem_wr_t          wr,
    output nsf_pkg::mem_rd_t          rd,
    output nsf_pkg::status_t          status
);
    import nsf_pkg::*;

    logic              in_frame_reg, in_frame_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              bank_reg, bank_next;
    logic [FILL_W-1:0] pub_len_reg, pub_len_next;
    logic              have_reg, have_next;
    logic [CNT_W-1:0]  age_reg, age_next;
    logic [CNT_W-1:0]  drop_reg, drop_next;
    logic [TMO_W-1:0]  timeout_reg;
    logic              done;
    logic              rd_hit;
    logic [CNT_W-1:0]  age_out;

    always_comb begin
        in_frame_next = in_frame_reg;
        fill_next     = fill_reg;
        bank_next     = bank_reg;
        pub_len_next  = pub_len_reg;
        have_next     = have_reg;
        age_next      = age_reg;
        drop_next     = drop_reg;
        done          = 1'b0;
        rd_hit        = 1'b0;
        wr            = '0;
        rd            = '0;
        if (accept) begin
            unique case (cmd)
                CMD_BYTE: begin
                    if (rx_byte == CH_START) begin
                        in_frame_next = 1'b1;
                        fill_next     = FILL_W'(1);
                        wr.we         = 1'b1;
                        wr.addr       = {bank_reg, {FILL_W{1'b0}}};
                        wr.data       = rx_byte;
                    end else if (in_frame_reg && rx_byte != CH_CR) begin
                        if (rx_byte == CH_LF) begin
                            if (fill_reg > FILL_W'(1)) begin
                                pub_len_next = fill_reg;
                                bank_next    = ~bank_reg;
                                have_next    = 1'b1;
                                age_next     = '0;
                                done         = 1'b1;
                            end
                            in_frame_next = 1'b0;
                            fill_next     = '0;
                        end else if (fill_reg < FILL_W'(SENTENCE_BYTES - 1)) begin
                            wr.we     = 1'b1;
                            wr.addr   = {bank_reg, fill_reg};
                            wr.data   = rx_byte;
                            fill_next = fill_reg + FILL_W'(1);
                        end else begin
                            drop_next     = drop_reg + CNT_W'(1);
                            in_frame_next = 1'b0;
                            fill_next     = '0;
                        end
                    end
                end
                CMD_TICK: begin
                    if (have_reg && age_reg != '1) begin
                        age_next = age_reg + CNT_W'(1);
                    end
                end
                CMD_READ: begin
                    rd.re   = 1'b1;
                    rd.addr = {~bank_reg, FILL_W'(read_index)};
                    rd_hit  = have_reg && (CMP_W'(read_index) < CMP_W'(pub_len_reg));
                end
                default: begin
                end
            endcase
        end
    end

    assign age_out        = have_next ? age_next : '0;
    assign status.done    = done;
    assign status.length  = have_next ? LEN_W'(pub_len_next) : '0;
    assign status.dropped = drop_next;
    assign status.age     = age_out;
    assign status.fresh   = have_next && (age_out <= CNT_W'(timeout_reg));
    assign status.rd_hit  = rd_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            fill_reg     <= '0;
            bank_reg     <= 1'b0;
            pub_len_reg  <= '0;
            have_reg     <= 1'b0;
            age_reg      <= '0;
            drop_reg     <= '0;
            timeout_reg  <= TIMEOUT_RESET;
        end else begin
            in_frame_reg <= in_frame_next;
            fill_reg     <= fill_next;
            bank_reg     <= bank_next;
            pub_len_reg  <= pub_len_next;
            have_reg     <= have_next;
            age_reg      <= age_next;
            drop_reg     <= drop_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

endmodule

[rtl/nmea_sentence_framer.sv]
`timescale 1ns / 1ps
// NMEA sentence framer.
// Slave stream: one beat per command. s_tuser carries the command (received
// byte, millisecond tick, read of the latest sentence, no-op); s_tdata carries the
// received character and the read index. '$' opens a sentence, LF publishes
// it (if it holds more than the '$') by swapping the banks of a two-bank byte
// store, overlong sentences are dropped and counted.
// Master stream: exactly one beat per slave beat, in order. m_tuser flags a
// beat that published a sentence; m_tdata carries length, read byte, drop
// count, age and the fresh flag, all taken after that command's update.
// Path: state update and store access when a beat is accepted (store read
// data registered), then the output register. Throughput: 1 beat per
// cycle while m_tready does not stall, set by the read-modify-write of the
// framing state on each accepted beat and one store port pair.
// Reset (aresetn low, synchronous) empties the pipeline, closes any frame,
// clears counters and sets the timeout to 1000 ms; store contents are kept.
// A master stall holds the output beat; one more beat can enter behind it,
// after that s_tready drops until m_tready returns.
// cfg_we/cfg_wdata write the stale timeout; write only while idle.

module nmea_sentence_framer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [nsf_pkg::TMO_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nsf_pkg::S_TDATA_W-1:0] s_tdata,  // rx_byte[7:0], read_index[14:8], zero pad
    input  logic [nsf_pkg::S_TUSER_W-1:0] s_tuser,  // cmd[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nsf_pkg::M_TDATA_W-1:0] m_tdata,  // latest_length[6:0], read_data[14:7],
                                                    // dropped_count[46:15], age_ms[78:47],
                                                    // fresh[79]
    output logic [nsf_pkg::M_TUSER_W-1:0] m_tuser   // sentence_done[0]
);
    import nsf_pkg::*;

    logic       accept;
    mem_wr_t    wr;
    mem_rd_t    rd;
    status_t    status;
    logic [7:0] store_q;

    logic       p1_valid_reg, p1_valid_next;
    status_t    p1_stat_reg;
    logic       m_valid_reg, m_valid_next;
    status_t    m_stat_reg;
    logic [7:0] m_rdata_reg;
    logic       p1_adv;

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    nsf_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .cmd        (cmd_t'(s_tuser[1:0])),
        .rx_byte    (s_tdata[7:0]),
        .read_index (s_tdata[14:8]),
        .wr         (wr),
        .rd         (rd),
        .status     (status)
    );

    nsf_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (store_q)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        m_valid_next  = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (p1_adv) begin
            m_valid_next  = 1'b1;
            p1_valid_next = 1'b0;
        end
        if (accept) begin
            p1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_stat_reg <= status;
        end
        if (p1_adv) begin
            m_stat_reg  <= p1_stat_reg;
            m_rdata_reg <= p1_stat_reg.rd_hit ? store_q : 8'h00;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_stat_reg.fresh, m_stat_reg.age, m_stat_reg.dropped,
                       m_rdata_reg, m_stat_reg.length};
    assign m_tuser  = m_stat_reg.done;

endmodule

[rtl/nsf_checker.sv]
`timescale 1ns / 1ps

module nsf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [nsf_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic [nsf_pkg::M_TUSER_W-1:0]  m_tuser
);
    import nsf_pkg::*;

    logic [LEN_W-1:0] len;
    logic [CNT_W-1:0] age;
    logic             fresh;

    assign len   = m_tdata[6:0];
    assign age   = m_tdata[78:47];
    assign fresh = m_tdata[79];

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat present after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output beat changed");

    a_done_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> age == '0 && fresh && len > LEN_W'(1))
        else $error("published beat with inconsistent status");

    a_fresh_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && fresh |-> len != '0)
        else $error("fresh without a sentence");

    a_age_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && age != '0 |-> len != '0)
        else $error("age counting without a sentence");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (.*);

[dv/nmea_sentence_framer_chk.sv]
`timescale 1ns / 1ps

module nmea_sentence_framer_chk
    import nsf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [TMO_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,
    output int                   mismatches,
    output int                   in_flight
);

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] length;
        logic [7:0]       rd_byte;
        logic [CNT_W-1:0] dropped;
        logic [CNT_W-1:0] age;
        logic             fresh;
    } framer_status_t;

    logic [7:0]       bank_bytes [STORE_DEPTH];
    logic             open_frame;
    int unsigned      fill;
    logic             bank;
    int unsigned      pub_len;
    logic             have_latest;
    logic [CNT_W-1:0] age_ms;
    logic [CNT_W-1:0] drops;
    logic [TMO_W-1:0] stale_lim;

    framer_status_t   status_q [$];

    function automatic void put_byte(input logic [7:0] ch);
        int base;
        base = bank ? SENTENCE_BYTES : 0;
        bank_bytes[base + int'(fill)] = ch;
        fill++;
    endfunction

    function automatic framer_status_t frame_step(input cmd_t cmd, input logic [7:0] ch,
                                                  input logic [IDX_W-1:0] ix);
        framer_status_t st;
        int             base;
        st = '0;
        case (cmd)
            CMD_BYTE: begin
                if (ch == CH_START) begin
                    fill       = 0;
                    open_frame = 1'b1;
                    put_byte(ch);
                end else if (open_frame && ch != CH_CR) begin
                    if (ch == CH_LF) begin
                        if (fill > 1) begin
                            pub_len     = fill;
                            bank        = ~bank;
                            have_latest = 1'b1;
                            age_ms      = '0;
                            st.done     = 1'b1;
                        end
                        fill       = 0;
                        open_frame = 1'b0;
                    end else if (fill < SENTENCE_BYTES - 1) begin
                        put_byte(ch);
                    end else begin
                        drops      = drops + 1'b1;
                        fill       = 0;
                        open_frame = 1'b0;
                    end
                end
            end
            CMD_TICK: begin
                if (have_latest && age_ms != '1)
                    age_ms = age_ms + 1'b1;
            end
            CMD_READ: begin
                if (have_latest && int'(ix) < pub_len) begin
                    base       = bank ? 0 : SENTENCE_BYTES;
                    st.rd_byte = bank_bytes[base + int'(ix)];
                end
            end
            default: ;
        endcase
        st.length  = have_latest ? LEN_W'(pub_len) : '0;
        st.dropped = drops;
        st.age     = have_latest ? age_ms : '0;
        st.fresh   = have_latest && (st.age <= CNT_W'(stale_lim));
        return st;
    endfunction

    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        framer_status_t want;
        framer_status_t got;
        if (!aresetn) begin
            open_frame  = 1'b0;
            fill        = 0;
            bank        = 1'b0;
            pub_len     = 0;
            have_latest = 1'b0;
            age_ms      = '0;
            drops       = '0;
            stale_lim   = TIMEOUT_RESET;
            status_q.delete();
            in_flight  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.done    = m_tuser[0];
                got.length  = m_tdata[6:0];
                got.rd_byte = m_tdata[14:7];
                got.dropped = m_tdata[46:15];
                got.age     = m_tdata[78:47];
                got.fresh   = m_tdata[79];
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    want = status_q.pop_front();
                    check_field("sentence_done", CNT_W'(want.done), CNT_W'(got.done));
                    check_field("latest_length", CNT_W'(want.length), CNT_W'(got.length));
                    check_field("read_data", CNT_W'(want.rd_byte), CNT_W'(got.rd_byte));
                    check_field("dropped_count", want.dropped, got.dropped);
                    check_field("age_ms", want.age, got.age);
                    check_field("fresh", CNT_W'(want.fresh), CNT_W'(got.fresh));
                end
            end
            if (cfg_we)
                stale_lim = cfg_wdata;
            if (s_tvalid && s_tready)
                status_q.push_back(frame_step(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[14:8]));
            in_flight <= status_q.size();
        end
    end

endmodule

[dv/nmea_sentence_framer_tb.sv]
`timescale 1ns / 1ps

module nmea_sentence_framer_tb;
    import nsf_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [TMO_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int mismatches;
    int in_flight;
    int beats_sent;
    int last_len;
    bit no_idle;
    bit hold_go;

    always #6 aclk = ~aclk;

    nmea_sentence_framer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    nmea_sentence_framer_chk i_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    task automatic send_beat(input cmd_t cmd, input logic [7:0] ch, input logic [IDX_W-1:0] ix);
        while (!no_idle && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= S_TDATA_W'({ix, ch});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_beat(CMD_BYTE, ch, IDX_W'($urandom));
    endtask

    task automatic send_read();
        int hi;
        hi = (last_len + 1 > 127) ? 127 : last_len + 1;
        if ($urandom_range(0, 3) == 0)
            send_beat(CMD_READ, 8'($urandom), IDX_W'($urandom_range(0, 127)));
        else
            send_beat(CMD_READ, 8'($urandom), IDX_W'($urandom_range(0, hi)));
    endtask

    function automatic logic [7:0] pick_body_char(input bit plain);
        logic [7:0] ch;
        if (!plain && $urandom_range(0, 99) < 6)
            return CH_CR;
        if (plain || $urandom_range(0, 99) < 80)
            ch = 8'($urandom_range(8'h20, 8'h7E));
        else
            ch = 8'($urandom_range(0, 255));
        if (ch == CH_START || ch == CH_LF)
            ch = 8'h2A;
        return ch;
    endfunction

    task automatic send_sentence(input int body, input bit with_lf, input bit plain);
        int         kept;
        logic [7:0] ch;
        kept = 1;
        send_char(CH_START);
        for (int k = 0; k < body; k++) begin
            ch = pick_body_char(plain);
            if (ch != CH_CR)
                kept++;
            send_char(ch);
        end
        if (with_lf) begin
            send_char(CH_LF);
            if (kept > 1 && kept < SENTENCE_BYTES)
                last_len = kept;
        end
    endtask

    // stop offering, let every result drain, then write the timeout
    task automatic set_timeout(input logic [TMO_W-1:0] value);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_random(input int budget, input bit with_hold);
        int stop_at;
        int hold_at;
        int pick;
        bit held;
        stop_at = beats_sent + budget;
        hold_at = beats_sent + budget / 3;
        held    = 1'b0;
        while (beats_sent < stop_at) begin
            if (with_hold && !held && beats_sent >= hold_at) begin
                hold_go = 1'b1;
                held    = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_sentence(($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 20),
                              $urandom_range(0, 9) != 0, 1'b0);
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 8)) send_beat(CMD_TICK, 8'($urandom), IDX_W'($urandom));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4)) send_read();
            end else begin
                send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom), IDX_W'($urandom));
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    initial begin
        int dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("nmea_sentence_framer_tb: FAIL");
        $finish;
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = CMD_BYTE;
        last_len  = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // default timeout, nothing published yet
        send_beat(CMD_TICK, 8'hFF, 7'h7F);
        send_beat(CMD_READ, 8'h00, 7'h00);
        send_beat(CMD_READ, 8'hFF, 7'h7F);
        send_char("A");
        send_char(CH_LF);
        send_char(CH_CR);
        send_char(CH_START);
        send_char(CH_LF);
        send_char(CH_START);
        send_char("G");
        send_char(CH_CR);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(CH_LF);
        last_len = 4;
        send_beat(CMD_READ, 8'h55, 7'd0);
        send_beat(CMD_READ, 8'hAA, 7'd2);
        send_beat(CMD_READ, 8'h00, 7'd3);
        send_beat(CMD_READ, 8'hFF, 7'd4);
        send_beat(CMD_NOP, 8'hFF, 7'h7F);
        send_beat(CMD_TICK, 8'h00, 7'h00);
        send_beat(CMD_TICK, 8'h5A, 7'h2A);
        send_char(CH_START);
        send_char("X");
        send_char(CH_START);
        send_char("Y");
        send_char(CH_LF);
        last_len = 2;
        send_beat(CMD_READ, 8'hC3, 7'd1);

        // longest sentence and overflow, back to back with no idling
        set_timeout('0);
        no_idle = 1'b1;
        send_sentence(SENTENCE_BYTES - 2, 1'b1, 1'b1);
        send_beat(CMD_READ, 8'h00, 7'd0);
        send_beat(CMD_READ, 8'h00, 7'd126);
        send_beat(CMD_READ, 8'h00, 7'd127);
        send_beat(CMD_TICK, 8'h00, 7'd0);
        send_sentence(SENTENCE_BYTES - 1, 1'b1, 1'b1);
        send_beat(CMD_READ, 8'h00, 7'd5);
        repeat (3) send_beat(CMD_TICK, 8'h00, 7'd0);
        no_idle = 1'b0;

        set_timeout('1);
        run_random(80, 1'b1);
        set_timeout(TMO_W'($urandom_range(2, 6)));
        run_random(80, 1'b0);

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("nmea_sentence_framer_tb: PASS");
        else
            $display("nmea_sentence_framer_tb: FAIL");
        $finish;
    end

endmodule

[nmea_sentence_framer.f]
rtl/nsf_pkg.sv
rtl/nsf_store.sv
rtl/nsf_ctrl.sv
rtl/nmea_sentence_framer.sv
rtl/nsf_checker.sv
dv/nmea_sentence_framer_chk.sv
dv/nmea_sentence_framer_tb.sv
